[rtl/bkvt_pkg.sv]
// ----------------------------------------------------------------------------
// bkvt_pkg
// Shared types and constants of the bounded key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package bkvt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CAP_W       = 5;
    localparam int SLOT_W      = 8;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int WIDE_W      = SLOT_W + CNT_W + CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_RELATE = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_INDEX  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value_in;
        logic [SLOT_W-1:0]       slot_index;
        logic signed [KEY_W-1:0] default_key;
    } in_item_t;

    typedef struct packed {
        logic                    hit;
        logic [4:0]              entry_count;
        logic [VAL_W-1:0]        value_out;
        logic signed [KEY_W-1:0] key_out;
    } out_item_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic             wr_key_en;
        logic [IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0] wr_key;
        logic [VAL_W-1:0] wr_value;
    } mem_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } mem_rsp_t;

endpackage

`default_nettype wire

[rtl/bounded_key_value_table.sv]
// ----------------------------------------------------------------------------
// bounded_key_value_table
// Fixed-capacity key/value table with relate, lookup, read-at-index, clear.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    bkvt_pkg::in_item_t
// m_        out        m_valid / m_ready    bkvt_pkg::out_item_t
// cfg_      in         cfg_wr_en            cfg_wr_data (capacity_in_use)
//
// Relate and lookup search the filled slots (count up to 16): the
// search reads one stored key per cycle through the single read port and
// checks it with one shared comparator. Reset clears the entry count and
// sets capacity to 16; the stored pairs need no clearing. A result waiting
// in the output register does not block the next item; the sequencer
// stalls only when a second result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_key_value_table (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire bkvt_pkg::in_item_t          s_item,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output bkvt_pkg::out_item_t              m_item,
    input  wire logic                        cfg_wr_en,
    input  wire logic [bkvt_pkg::CAP_W-1:0]  cfg_wr_data
);

    logic [bkvt_pkg::CAP_W-1:0] cap_reg;
    logic                       m_valid_reg;
    bkvt_pkg::out_item_t        m_item_reg;

    logic                       res_valid;
    logic                       res_ready;
    bkvt_pkg::out_item_t        res_item;
    bkvt_pkg::mem_req_t         mem_req;
    bkvt_pkg::mem_rsp_t         mem_rsp;

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= bkvt_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid && res_ready) begin
            m_item_reg <= res_item;
        end
    end

    bkvt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cap       (cap_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp)
    );

    bkvt_mem u_mem (
        .aclk (aclk),
        .req  (mem_req),
        .rsp  (mem_rsp)
    );

endmodule

`default_nettype wire

[rtl/bkvt_mem.sv]
// ----------------------------------------------------------------------------
// bkvt_mem
// Key and value storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bkvt_mem (
    input  wire logic              aclk,
    input  wire bkvt_pkg::mem_req_t req,
    output bkvt_pkg::mem_rsp_t      rsp
);

    logic [bkvt_pkg::KEY_W-1:0] key_mem [bkvt_pkg::TABLE_DEPTH];
    logic [bkvt_pkg::VAL_W-1:0] val_mem [bkvt_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            val_mem[req.wr_addr] <= req.wr_value;
            if (req.wr_key_en) begin
                key_mem[req.wr_addr] <= req.wr_key;
            end
        end
        if (req.rd_en) begin
            rsp.key   <= key_mem[req.rd_addr];
            rsp.value <= val_mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/bkvt_ctrl.sv]
// ----------------------------------------------------------------------------
// bkvt_ctrl
// Command sequencer: linear key search with one shared key comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module bkvt_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire bkvt_pkg::in_item_t           s_item,
    input  wire logic [bkvt_pkg::CAP_W-1:0]   cap,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output bkvt_pkg::out_item_t               res_item,
    output bkvt_pkg::mem_req_t                mem_req,
    input  wire bkvt_pkg::mem_rsp_t           mem_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INDEX,
        ST_FINISH
    } state_t;

    state_t                          state_reg,   state_next;
    bkvt_pkg::in_item_t              item_reg,    item_next;
    logic [bkvt_pkg::CNT_W-1:0]      count_reg,   count_next;
    logic [bkvt_pkg::CNT_W-1:0]      issue_reg,   issue_next;
    logic [bkvt_pkg::IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                            pend_reg,    pend_next;
    bkvt_pkg::out_item_t             res_reg,     res_next;

    logic                            match;
    logic                            room;
    logic                            in_range;
    logic [bkvt_pkg::CNT_W-1:0]      limit;

    always_comb begin
        if (bkvt_pkg::WIDE_W'(cap) > bkvt_pkg::WIDE_W'(bkvt_pkg::TABLE_DEPTH)) begin
            limit = bkvt_pkg::CNT_W'(bkvt_pkg::TABLE_DEPTH);
        end else begin
            limit = bkvt_pkg::CNT_W'(cap);
        end
    end

    assign match    = pend_reg && (mem_rsp.key == item_reg.key);
    assign room     = count_reg < limit;
    assign in_range = bkvt_pkg::WIDE_W'(s_item.slot_index) < bkvt_pkg::WIDE_W'(count_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);
    assign res_item  = res_reg;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        count_next   = count_reg;
        issue_next   = issue_reg;
        cmp_idx_next = cmp_idx_reg;
        pend_next    = pend_reg;
        res_next     = res_reg;
        mem_req      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_item;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    case (s_item.command)
                        bkvt_pkg::CMD_CLEAR: begin
                            count_next = '0;
                            res_next   = '0;
                            state_next = ST_FINISH;
                        end
                        bkvt_pkg::CMD_INDEX: begin
                            mem_req.rd_en   = in_range;
                            mem_req.rd_addr = bkvt_pkg::IDX_W'(s_item.slot_index);
                            pend_next       = in_range;
                            state_next      = ST_INDEX;
                        end
                        default: begin
                            state_next = ST_SEARCH;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (match) begin
                    res_next.hit         = 1'b1;
                    res_next.entry_count = 5'(count_reg);
                    res_next.key_out     = '0;
                    if (item_reg.command == bkvt_pkg::CMD_RELATE) begin
                        mem_req.wr_en     = 1'b1;
                        mem_req.wr_addr   = cmp_idx_reg;
                        mem_req.wr_value  = item_reg.value_in;
                        res_next.value_out = '0;
                    end else begin
                        res_next.value_out = mem_rsp.value;
                    end
                    pend_next  = 1'b0;
                    state_next = ST_FINISH;
                end else if (issue_reg < count_reg) begin
                    // advance: fetch next slot, compare it next cycle
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = issue_reg[bkvt_pkg::IDX_W-1:0];
                    cmp_idx_next    = issue_reg[bkvt_pkg::IDX_W-1:0];
                    pend_next       = 1'b1;
                    issue_next      = issue_reg + 1'b1;
                end else begin
                    res_next           = '0;
                    res_next.entry_count = 5'(count_reg);
                    if ((item_reg.command == bkvt_pkg::CMD_RELATE) && room) begin
                        mem_req.wr_en     = 1'b1;
                        mem_req.wr_key_en = 1'b1;
                        mem_req.wr_addr   = count_reg[bkvt_pkg::IDX_W-1:0];
                        mem_req.wr_key    = item_reg.key;
                        mem_req.wr_value  = item_reg.value_in;
                        count_next        = count_reg + 1'b1;
                        res_next.hit      = 1'b1;
                        res_next.entry_count = 5'(count_reg + 1'b1);
                    end
                    pend_next  = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_INDEX: begin
                res_next.hit         = pend_reg;
                res_next.entry_count = 5'(count_reg);
                if (pend_reg) begin
                    res_next.key_out   = mem_rsp.key;
                    res_next.value_out = mem_rsp.value;
                end else begin
                    res_next.key_out   = item_reg.default_key;
                    res_next.value_out = '0;
                end
                pend_next  = 1'b0;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
        item_reg    <= item_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bkvt_pkg::CNT_W'(bkvt_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + 1'b1) || (count_reg == '0))
        else $error("entry count moved by more than one");

    a_write_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == ST_SEARCH))
        else $error("table written outside key search");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (issue_reg <= count_reg))
        else $error("search ran past the filled slots");

    a_search_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) && match |=> (state_reg == ST_FINISH))
        else $error("key match did not end the search");

endmodule

`default_nettype wire
